// ===== design/rhr_pkg.sv =====
// Shared widths for the hue rotation block and its channel interfaces.
package rhr_pkg;

    // Width of one color channel
    localparam int unsigned PIX_W   = 8;
    // Width of the hue shift in degrees
    localparam int unsigned SHIFT_W = 9;

endpackage

// ===== design/rhr_in_if.sv =====
// Input channel: one RGB pixel and its hue shift per transaction.
interface rhr_in_if;
    import rhr_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   red_in;
    logic [PIX_W-1:0]   green_in;
    logic [PIX_W-1:0]   blue_in;
    logic [SHIFT_W-1:0] hue_shift;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output hue_shift, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input hue_shift, output ready);
endinterface

// ===== design/rhr_out_if.sv =====
// Output channel: one rotated RGB pixel per transaction.
interface rhr_out_if;
    import rhr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

// ===== design/rgb_hue_rotate_unit.sv =====
// RGB hue rotation: each transaction on i_pix carries an 8-bit RGB pixel and a hue shift in
// degrees; the pixel is taken to integer HSV (hue 0..359, saturation and value 0..100, all
// quotients rounded half away from zero), the hue is advanced by the shift modulo 360 (a
// result of 0 becomes 1), and the pixel is rebuilt at 255 scale and sent on o_pix. Gray
// pixels keep hue 0. The block is a 12-stage pipeline that takes one pixel every clock while
// the output is not stalled; the two divisions (hue by chroma, saturation by max) run as
// restoring dividers that settle three quotient bits per stage over three stages, and the
// constant divisions are reciprocal multiplies. When o_pix holds a pixel and o_pix.ready is
// low, the whole pipeline holds and i_pix.ready drops with it, so no new pixel is taken until
// the output pixel moves, even if bubbles remain further up the pipeline.
module rgb_hue_rotate_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhr_in_if.sink    i_pix,
    rhr_out_if.source o_pix
);
    import rhr_pkg::*;

    localparam int unsigned NSTG   = 12;
    localparam int unsigned HN_W   = 18;   // divider dividend / remainder
    localparam int unsigned HD_W   = 9;    // divider divisor
    localparam int unsigned HQ_W   = 9;    // divider quotient
    localparam int unsigned VAL_W  = 7;    // value and saturation, 0..100
    localparam int unsigned VP_W   = 33;
    localparam int unsigned VAL_SH = 25;
    localparam int unsigned U_W    = 20;   // channel units of 1/600000
    localparam int unsigned Y_W    = 24;
    localparam int unsigned Z_W    = 18;
    localparam int unsigned CP_W   = 36;
    localparam int unsigned CH_SH  = 27;

    localparam logic [VP_W-1:0] VAL_MUL  = 33'd65794;   // ceil(2^25 / 510)
    localparam logic [CP_W-1:0] CH_MUL   = 36'd214749;  // ceil(2^27 / 625)
    localparam logic [9:0]      DEG_FULL = 10'd360;
    localparam logic [9:0]      DEG_TWO  = 10'd720;
    localparam logic [5:0]      DEG_SEXT = 6'd60;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } t_max_src;

    // Sextant of the rotated hue
    typedef enum logic [2:0] {
        SXT_RY = 3'd0,
        SXT_YG = 3'd1,
        SXT_GC = 3'd2,
        SXT_CB = 3'd3,
        SXT_BM = 3'd4,
        SXT_MR = 3'd5
    } t_sextant;

    typedef struct packed {
        logic [HN_W-1:0] rem;
        logic [HQ_W-1:0] q;
    } t_div;

    localparam logic [1:0] U_CM = 2'd0;
    localparam logic [1:0] U_MM = 2'd1;
    localparam logic [1:0] U_XM = 2'd2;

    // Three restoring steps, quotient bits top down to top-2
    function automatic t_div div_bits3(t_div s, logic [HD_W-1:0] d, int unsigned top);
        t_div            o;
        logic [HN_W-1:0] trial;
        o = s;
        for (int i = 0; i < 3; i++) begin
            trial = HN_W'(d) << (top - i);
            if (o.rem >= trial) begin
                o.rem = o.rem - trial;
                o.q   = {o.q[HQ_W-2:0], 1'b1};
            end else begin
                o.q   = {o.q[HQ_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // floor((u*17 + 20000) / 64); the rest of the /40000 is a reciprocal multiply
    function automatic logic [Z_W-1:0] chan_pre(logic [U_W-1:0] u);
        logic [Y_W-1:0] y;
        y = Y_W'(u) * Y_W'(17) + Y_W'(20000);
        return Z_W'(y >> 6);
    endfunction

    logic              adv;
    logic [NSTG-1:0]   r_vld;

    // stage 1
    logic [PIX_W-1:0]   s1_mx, s1_mn;
    t_max_src           s1_src;
    logic signed [8:0]  s1_d;
    logic [PIX_W-1:0]   r1_mx, r1_c;
    t_max_src           r1_src;
    logic signed [8:0]  r1_d;
    logic [SHIFT_W-1:0] r1_shift;

    // stage 2
    logic signed [HN_W-1:0] s2_num;
    logic [HN_W-1:0]        s2_off;
    logic [HN_W-2:0]        s2_abs;
    logic [HN_W-1:0]        r2_hn, r2_sn;
    logic [HD_W-1:0]        r2_hd, r2_sd;
    logic                   r2_neg, r2_gray, r2_szero;
    logic [15:0]            r2_vx;
    logic [SHIFT_W-1:0]     r2_shift;

    // stages 3..5: dividers
    t_div               r3_hdiv, r3_sdiv, r4_hdiv, r4_sdiv, r5_hdiv, r5_sdiv;
    logic [HD_W-1:0]    r3_hd, r3_sd, r4_hd, r4_sd;
    logic [VP_W-1:0]    r3_vp;
    logic [VAL_W-1:0]   r4_val, r5_val;
    logic               r3_neg, r3_gray, r3_szero;
    logic               r4_neg, r4_gray, r4_szero;
    logic               r5_neg, r5_gray, r5_szero;
    logic [SHIFT_W-1:0] r3_shift, r4_shift, r5_shift;

    // stage 6
    logic [8:0]       s6_hue;
    logic [9:0]       s6_sum, s6_mod;
    logic [8:0]       r6_h;
    logic [VAL_W-1:0] r6_val, r6_sat;

    // stage 7
    t_sextant         s7_k;
    logic [8:0]       s7_base;
    logic [5:0]       s7_rem, s7_t;
    t_sextant         r7_k;
    logic [5:0]       r7_t;
    logic [13:0]      r7_vs;
    logic [VAL_W-1:0] r7_val;

    // stages 8..12
    t_sextant         r8_k, r9_k, r10_k, r11_k;
    logic [U_W-1:0]   r8_cm, r8_vs60, r8_vst;
    logic [U_W-1:0]   r9_u  [3];
    logic [Z_W-1:0]   r10_z [3];
    logic [CP_W-1:0]  r11_p [3];
    logic [PIX_W-1:0] s12_ch [3];
    logic [PIX_W-1:0] r12_red, r12_green, r12_blue;

    // Pipeline advances unless the output register is full and stalled
    assign adv         = !r_vld[NSTG-1] || o_pix.ready;
    assign i_pix.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // Max, min and the signed channel difference of the hue sextant formula
    always_comb begin
        if (i_pix.red_in >= i_pix.green_in && i_pix.red_in >= i_pix.blue_in) begin
            s1_src = MAX_RED;
            s1_mx  = i_pix.red_in;
        end else if (i_pix.green_in >= i_pix.blue_in) begin
            s1_src = MAX_GREEN;
            s1_mx  = i_pix.green_in;
        end else begin
            s1_src = MAX_BLUE;
            s1_mx  = i_pix.blue_in;
        end
        s1_mn = (i_pix.red_in <= i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in < s1_mn) begin
            s1_mn = i_pix.blue_in;
        end
        case (s1_src)
            MAX_RED:   s1_d = $signed({1'b0, i_pix.green_in}) - $signed({1'b0, i_pix.blue_in});
            MAX_GREEN: s1_d = $signed({1'b0, i_pix.blue_in}) - $signed({1'b0, i_pix.red_in});
            default:   s1_d = $signed({1'b0, i_pix.red_in}) - $signed({1'b0, i_pix.green_in});
        endcase
    end

    // Hue numerator with its sextant offset, folded to magnitude for the divider
    always_comb begin
        case (r1_src)
            MAX_GREEN: s2_off = HN_W'(r1_c) * HN_W'(120);
            MAX_BLUE:  s2_off = HN_W'(r1_c) * HN_W'(240);
            default:   s2_off = '0;
        endcase
        s2_num = $signed(HN_W'(r1_d) * HN_W'(60) + s2_off);
        s2_abs = s2_num[HN_W-1] ? (HN_W-1)'(-s2_num) : (HN_W-1)'(s2_num);
    end

    // Stage 6: undo sign, add shift, wrap to 0..359, zero becomes one
    always_comb begin
        if (r5_gray) begin
            s6_hue = '0;
        end else if (r5_neg && r5_hdiv.q != '0) begin
            s6_hue = 9'(DEG_FULL) - r5_hdiv.q;
        end else begin
            s6_hue = r5_hdiv.q;
        end
        s6_sum = 10'(s6_hue) + 10'(r5_shift);
        if (s6_sum >= DEG_TWO) begin
            s6_mod = s6_sum - DEG_TWO;
        end else if (s6_sum >= DEG_FULL) begin
            s6_mod = s6_sum - DEG_FULL;
        end else begin
            s6_mod = s6_sum;
        end
        if (s6_mod == '0) begin
            s6_mod = 10'd1;
        end
    end

    // Stage 7: sextant, remainder and the rising/falling weight
    always_comb begin
        if (r6_h >= 9'd300) begin
            s7_k = SXT_MR; s7_base = 9'd300;
        end else if (r6_h >= 9'd240) begin
            s7_k = SXT_BM; s7_base = 9'd240;
        end else if (r6_h >= 9'd180) begin
            s7_k = SXT_CB; s7_base = 9'd180;
        end else if (r6_h >= 9'd120) begin
            s7_k = SXT_GC; s7_base = 9'd120;
        end else if (r6_h >= 9'd60) begin
            s7_k = SXT_YG; s7_base = 9'd60;
        end else begin
            s7_k = SXT_RY; s7_base = 9'd0;
        end
        s7_rem = 6'(r6_h - s7_base);
        case (s7_k) inside
            SXT_YG, SXT_CB, SXT_MR: s7_t = DEG_SEXT - s7_rem;
            default:                s7_t = s7_rem;
        endcase
    end

    // Stage 12: scale back to 0..255
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s12_ch[i] = PIX_W'(r11_p[i] >> CH_SH);
        end
    end

    // Datapath registers; all hold while stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1
            r1_mx    <= s1_mx;
            r1_c     <= s1_mx - s1_mn;
            r1_src   <= s1_src;
            r1_d     <= s1_d;
            r1_shift <= i_pix.hue_shift;

            // stage 2: round-half-up dividends and doubled divisors
            r2_hn    <= {s2_abs, 1'b0} + HN_W'(r1_c);
            r2_hd    <= {r1_c, 1'b0};
            r2_neg   <= s2_num[HN_W-1];
            r2_gray  <= (r1_c == '0);
            r2_sn    <= HN_W'(r1_c) * HN_W'(200) + HN_W'(r1_mx);
            r2_sd    <= {r1_mx, 1'b0};
            r2_szero <= (r1_mx <= 8'd1);
            r2_vx    <= 16'(r1_mx) * 16'd200 + 16'd255;
            r2_shift <= r1_shift;

            // stage 3
            r3_hdiv  <= div_bits3('{rem: r2_hn, q: '0}, r2_hd, 8);
            r3_sdiv  <= div_bits3('{rem: r2_sn, q: '0}, r2_sd, 8);
            r3_hd    <= r2_hd;
            r3_sd    <= r2_sd;
            r3_vp    <= VP_W'(r2_vx) * VAL_MUL;
            r3_neg   <= r2_neg;
            r3_gray  <= r2_gray;
            r3_szero <= r2_szero;
            r3_shift <= r2_shift;

            // stage 4
            r4_hdiv  <= div_bits3(r3_hdiv, r3_hd, 5);
            r4_sdiv  <= div_bits3(r3_sdiv, r3_sd, 5);
            r4_hd    <= r3_hd;
            r4_sd    <= r3_sd;
            r4_val   <= VAL_W'(r3_vp >> VAL_SH);
            r4_neg   <= r3_neg;
            r4_gray  <= r3_gray;
            r4_szero <= r3_szero;
            r4_shift <= r3_shift;

            // stage 5
            r5_hdiv  <= div_bits3(r4_hdiv, r4_hd, 2);
            r5_sdiv  <= div_bits3(r4_sdiv, r4_sd, 2);
            r5_val   <= r4_val;
            r5_neg   <= r4_neg;
            r5_gray  <= r4_gray;
            r5_szero <= r4_szero;
            r5_shift <= r4_shift;

            // stage 6
            r6_h     <= 9'(s6_mod);
            r6_val   <= r5_val;
            r6_sat   <= r5_szero ? '0 : VAL_W'(r5_sdiv.q);

            // stage 7
            r7_k     <= s7_k;
            r7_t     <= s7_t;
            r7_vs    <= 14'(r6_val) * 14'(r6_sat);
            r7_val   <= r6_val;

            // stage 8: products in units of 1/600000
            r8_k     <= r7_k;
            r8_cm    <= U_W'(r7_val) * U_W'(6000);
            r8_vs60  <= U_W'(r7_vs) * U_W'(60);
            r8_vst   <= U_W'(r7_vs) * U_W'(r7_t);

            // stage 9: C+m, m, X+m
            r9_k       <= r8_k;
            r9_u[U_CM] <= r8_cm;
            r9_u[U_MM] <= r8_cm - r8_vs60;
            r9_u[U_XM] <= r8_cm - r8_vs60 + r8_vst;

            // stages 10, 11: rounding scale to 255
            r10_k <= r9_k;
            r11_k <= r10_k;
            for (int i = 0; i < 3; i++) begin
                r10_z[i] <= chan_pre(r9_u[i]);
                r11_p[i] <= CP_W'(r10_z[i]) * CH_MUL;
            end

            // stage 12: route by sextant
            case (r11_k)
                SXT_RY: begin
                    r12_red <= s12_ch[U_CM]; r12_green <= s12_ch[U_XM]; r12_blue <= s12_ch[U_MM];
                end
                SXT_YG: begin
                    r12_red <= s12_ch[U_XM]; r12_green <= s12_ch[U_CM]; r12_blue <= s12_ch[U_MM];
                end
                SXT_GC: begin
                    r12_red <= s12_ch[U_MM]; r12_green <= s12_ch[U_CM]; r12_blue <= s12_ch[U_XM];
                end
                SXT_CB: begin
                    r12_red <= s12_ch[U_MM]; r12_green <= s12_ch[U_XM]; r12_blue <= s12_ch[U_CM];
                end
                SXT_BM: begin
                    r12_red <= s12_ch[U_XM]; r12_green <= s12_ch[U_MM]; r12_blue <= s12_ch[U_CM];
                end
                default: begin
                    r12_red <= s12_ch[U_CM]; r12_green <= s12_ch[U_MM]; r12_blue <= s12_ch[U_XM];
                end
            endcase
        end
    end

    assign o_pix.valid     = r_vld[NSTG-1];
    assign o_pix.red_out   = r12_red;
    assign o_pix.green_out = r12_green;
    assign o_pix.blue_out  = r12_blue;

endmodule

// ===== bench/rgb_hue_rotate_checker.sv =====
`timescale 1ns / 100ps
// Checker for the hue rotation unit: predicts each rotated pixel and compares the output.
module rgb_hue_rotate_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rhr_in_if    i_pix,
    rhr_out_if   i_rot,
    output int   o_fail_count,
    output int   o_pending
);
    import rhr_pkg::*;

    localparam longint DEG_FULL   = 360;
    localparam longint DEG_SEXT   = 60;
    localparam longint CH_MAX     = 255;
    localparam longint PCT        = 100;
    localparam longint PCT_SQ     = 10000;
    localparam longint UNIT_DEN   = 600000;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb_pixel;

    // Rotated pixels still owed by the unit, oldest first
    t_rgb_pixel rotated_q[$];
    int         fail_count = 0;

    // Nearest integer, ties away from zero; den is positive
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    // Scale 1/600000 units to an 8-bit channel
    function automatic logic [PIX_W-1:0] units_to_channel(input longint units);
        longint level;
        level = round_div(units * CH_MAX, UNIT_DEN);
        return level[PIX_W-1:0];
    endfunction

    // RGB -> integer HSV, hue advanced by the shift, then back to RGB
    function automatic t_rgb_pixel rotate_hue_pixel(
        input logic [PIX_W-1:0]   red,
        input logic [PIX_W-1:0]   green,
        input logic [PIX_W-1:0]   blue,
        input logic [SHIFT_W-1:0] shift
    );
        longint     r, g, b, mx, mn, chroma, hue, val, sat;
        longint     vs, full, base, mixed, h, sext, rem, wt;
        t_rgb_pixel px;
        r = red;
        g = green;
        b = blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        chroma = mx - mn;

        // Gray pixels keep hue 0
        hue = 0;
        if (chroma != 0) begin
            if (r == mx) begin
                hue = round_div((g - b) * DEG_SEXT, chroma);
                if (hue < 0) hue += DEG_FULL;
            end else if (g == mx) begin
                hue = round_div((b - r) * DEG_SEXT + 2 * DEG_SEXT * chroma, chroma);
            end else begin
                hue = round_div((r - g) * DEG_SEXT + 4 * DEG_SEXT * chroma, chroma);
            end
            hue = hue % DEG_FULL;
        end

        val = round_div(mx * PCT, CH_MAX);
        sat = (val == 0) ? 0 : round_div(chroma * PCT, mx);

        // Rotated hue of 0 is forced to 1
        h = (hue + longint'(shift)) % DEG_FULL;
        if (h == 0) h = 1;
        sext = h / DEG_SEXT;
        rem  = h % DEG_SEXT;
        wt   = (sext % 2 == 0) ? rem : (DEG_SEXT - rem);

        vs    = val * sat;
        full  = val * (UNIT_DEN / PCT);
        base  = full - vs * (UNIT_DEN / PCT_SQ);
        mixed = base + vs * wt;

        case (sext)
            0: begin
                px.red = units_to_channel(full);  px.green = units_to_channel(mixed);
                px.blue = units_to_channel(base);
            end
            1: begin
                px.red = units_to_channel(mixed); px.green = units_to_channel(full);
                px.blue = units_to_channel(base);
            end
            2: begin
                px.red = units_to_channel(base);  px.green = units_to_channel(full);
                px.blue = units_to_channel(mixed);
            end
            3: begin
                px.red = units_to_channel(base);  px.green = units_to_channel(mixed);
                px.blue = units_to_channel(full);
            end
            4: begin
                px.red = units_to_channel(mixed); px.green = units_to_channel(base);
                px.blue = units_to_channel(full);
            end
            default: begin
                px.red = units_to_channel(full);  px.green = units_to_channel(base);
                px.blue = units_to_channel(mixed);
            end
        endcase
        return px;
    endfunction

    // Compare one channel of a result
    task automatic check_channel(input string label, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    // Predict on each input transaction, compare on each output transaction
    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n) begin
            if (i_pix.valid && i_pix.ready)
                rotated_q.push_back(rotate_hue_pixel(i_pix.red_in, i_pix.green_in,
                                                     i_pix.blue_in, i_pix.hue_shift));
            if (i_rot.valid && i_rot.ready) begin
                if (rotated_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected pixel: expected none actual %0d %0d %0d",
                             $time, i_rot.red_out, i_rot.green_out, i_rot.blue_out);
                end else begin
                    want = rotated_q.pop_front();
                    check_channel("red_out", want.red, i_rot.red_out);
                    check_channel("green_out", want.green, i_rot.green_out);
                    check_channel("blue_out", want.blue, i_rot.blue_out);
                end
            end
        end
        o_pending    <= rotated_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== bench/rgb_hue_rotate_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the hue rotation bench: clock, reset, pixel stimulus, output stalls and verdict.
module rgb_hue_rotate_unit_tb;
    import rhr_pkg::*;

    localparam int N_RANDOM     = 1200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left = 0;
    bit   tx_steady = 1'b0;

    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [15:0] rx_pattern = 16'h0;

    rhr_in_if  pix_if ();
    rhr_out_if rot_if ();

    rgb_hue_rotate_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_if),
        .o_pix   (rot_if)
    );

    rgb_hue_rotate_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_if),
        .i_rot        (rot_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL rgb_hue_rotate_unit");
            $finish;
        end
    end

    // Output stalls: ready follows a randomly chosen mode that is picked anew when its run ends
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode    = t_rx_mode'($urandom_range(0, 3));
            rx_left    = $urandom_range(16, 160);
            rx_pattern = 16'($urandom);
        end
        rx_left--;
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        case (rx_mode)
            RX_OPEN:    rot_if.ready <= 1'b1;
            RX_COIN:    rot_if.ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: rot_if.ready <= rx_pattern[0];
            default:    rot_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // One pixel transaction; bursts with random gaps, some bursts back to back
    task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue, input logic [SHIFT_W-1:0] shift);
        int gap;
        if (burst_left == 0) begin
            if (!tx_steady) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
                pix_if.valid     <= 1'b0;
                pix_if.red_in    <= PIX_W'($urandom);
                pix_if.green_in  <= PIX_W'($urandom);
                pix_if.blue_in   <= PIX_W'($urandom);
                pix_if.hue_shift <= SHIFT_W'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
            tx_steady  = ($urandom_range(0, 4) == 0);
        end
        burst_left--;
        pix_if.valid     <= 1'b1;
        pix_if.red_in    <= red;
        pix_if.green_in  <= green;
        pix_if.blue_in   <= blue;
        pix_if.hue_shift <= shift;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
    endtask

    // Channels x, y, z placed in one of the six orders
    task automatic send_permuted(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                                 input logic [PIX_W-1:0] z, input int order,
                                 input logic [SHIFT_W-1:0] shift);
        case (order)
            0:       send_pixel(x, y, z, shift);
            1:       send_pixel(x, z, y, shift);
            2:       send_pixel(y, x, z, shift);
            3:       send_pixel(y, z, x, shift);
            4:       send_pixel(z, x, y, shift);
            default: send_pixel(z, y, x, shift);
        endcase
    endtask

    initial begin
        logic [PIX_W-1:0]   hi, lo, mid;
        logic [SHIFT_W-1:0] sh;
        int                 kind;

        rst_n            <= 1'b0;
        pix_if.valid     <= 1'b0;
        pix_if.red_in    <= '0;
        pix_if.green_in  <= '0;
        pix_if.blue_in   <= '0;
        pix_if.hue_shift <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, grays, each sextant, zero hue, wrapping shifts
        send_pixel(8'd0,   8'd0,   8'd0,   9'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd359);
        send_pixel(8'd128, 8'd128, 8'd128, 9'd90);
        send_pixel(8'd255, 8'd0,   8'd0,   9'd0);
        send_pixel(8'd0,   8'd255, 8'd0,   9'd240);
        send_pixel(8'd0,   8'd0,   8'd255, 9'd120);
        send_pixel(8'd255, 8'd0,   8'd0,   9'd511);
        send_pixel(8'd0,   8'd255, 8'd0,   9'd360);
        send_pixel(8'd10,  8'd200, 8'd30,  9'd400);
        send_pixel(8'd255, 8'd0,   8'd10,  9'd0);
        send_pixel(8'd255, 8'd128, 8'd0,   9'd0);
        send_pixel(8'd128, 8'd255, 8'd0,   9'd0);
        send_pixel(8'd0,   8'd255, 8'd128, 9'd0);
        send_pixel(8'd0,   8'd128, 8'd255, 9'd0);
        send_pixel(8'd128, 8'd0,   8'd255, 9'd0);
        send_pixel(8'd255, 8'd0,   8'd128, 9'd0);
        send_pixel(8'd1,   8'd0,   8'd0,   9'd30);
        send_pixel(8'd255, 8'd255, 8'd0,   9'd17);
        send_pixel(8'd0,   8'd255, 8'd255, 9'd200);
        send_pixel(8'd255, 8'd0,   8'd255, 9'd300);
        send_pixel(8'd200, 8'd100, 8'd50,  9'd256);
        send_pixel(8'd37,  8'd1,   8'd254, 9'd300);
        send_pixel(8'd3,   8'd2,   8'd1,   9'd180);

        // Random pixels, weighted toward grays, pure hues, ties and dark values
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            hi   = PIX_W'($urandom);
            lo   = PIX_W'($urandom);
            mid  = PIX_W'($urandom);
            sh   = ($urandom_range(0, 4) == 0) ? SHIFT_W'($urandom)
                                               : SHIFT_W'($urandom_range(0, 359));
            case (kind)
                0: send_pixel(mid, mid, mid, sh);
                1: send_permuted(8'd255, 8'd0, mid, $urandom_range(0, 5), sh);
                2: send_permuted(hi, hi, lo, $urandom_range(0, 5), sh);
                3: send_pixel(PIX_W'($urandom_range(0, 3)), PIX_W'($urandom_range(0, 3)),
                              PIX_W'($urandom_range(0, 3)), sh);
                default: send_pixel(hi, lo, mid, sh);
            endcase
        end
        pix_if.valid <= 1'b0;

        // Drain: every pixel back, then a margin past the pipeline depth
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS rgb_hue_rotate_unit");
        else
            $display("FAIL rgb_hue_rotate_unit");
        $finish;
    end

endmodule

// ===== files.f =====
design/rhr_pkg.sv
design/rhr_in_if.sv
design/rhr_out_if.sv
design/rgb_hue_rotate_unit.sv
bench/rgb_hue_rotate_checker.sv
bench/rgb_hue_rotate_unit_tb.sv
